FILE: sv/segmented_deque_assert.svh
// assertion macros for the segmented deque checker
`ifndef SEGMENTED_DEQUE_ASSERT_SVH
`define SEGMENTED_DEQUE_ASSERT_SVH

// checked while out of reset
`define SD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define SD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/sd_pkg.sv
package sd_pkg;

   localparam int MAP_SLOTS_DEF  = 8;
   localparam int BLOCK_SIZE_DEF = 8;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_READ_IDX   = 3'd4,
      CMD_WRITE_IDX  = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // where the response data comes from
   typedef enum logic [1:0] {
      DSEL_ZERO = 2'd0,
      DSEL_ONES = 2'd1,
      DSEL_RAM  = 2'd2
   } dsel_type;

   typedef struct packed {
      status_type         status;
      dsel_type           dsel;
      logic [COUNT_W-1:0] count;
   } sd_resp_type;

endpackage

FILE: sv/sd_ram.sv
module sd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/sd_ctrl.sv
module sd_ctrl import sd_pkg::*; #(
   parameter int MAP_SLOTS  = MAP_SLOTS_DEF,
   parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
   localparam int DEPTH = MAP_SLOTS * BLOCK_SIZE,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [CMD_W-1:0]   cmd,
   input  logic [INDEX_W-1:0] index,
   output logic               ram_we,
   output logic               ram_re,
   output logic [AW-1:0]      ram_addr,
   output sd_resp_type        resp
);

   localparam int BW        = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
   localparam int OW        = $clog2(BLOCK_SIZE);
   localparam int CW        = $clog2(DEPTH + 1);
   localparam int MID_OFF   = BLOCK_SIZE / 2;
   localparam int RESET_BLK = MAP_SLOTS / 2;
   localparam int RESET_POS = RESET_BLK * BLOCK_SIZE + MID_OFF;

   logic [AW-1:0] head_pos_ff, head_pos_in, tail_pos_ff, tail_pos_in;
   logic [OW-1:0] head_off_ff, head_off_in, tail_off_ff, tail_off_in;
   logic [BW-1:0] head_blk_ff, head_blk_in, tail_blk_ff, tail_blk_in;
   logic [CW-1:0] count_ff, count_in;

   logic          we_c, re_c;
   logic          empty, last, in_range;
   status_type    status_c;
   dsel_type      dsel_c;

   function automatic logic [AW-1:0] mid_pos(input logic [BW-1:0] blk);
      return AW'(AW'(blk) * AW'(BLOCK_SIZE) + AW'(MID_OFF));
   endfunction

   assign empty    = (count_ff == '0);
   assign last     = (count_ff == CW'(1));
   assign in_range = (32'(index) < 32'(count_ff));

   always_comb begin
      head_pos_in = head_pos_ff;
      head_off_in = head_off_ff;
      head_blk_in = head_blk_ff;
      tail_pos_in = tail_pos_ff;
      tail_off_in = tail_off_ff;
      tail_blk_in = tail_blk_ff;
      count_in    = count_ff;
      we_c        = 1'b0;
      re_c        = 1'b0;
      ram_addr    = head_pos_ff;
      status_c    = ST_OK;
      dsel_c      = DSEL_ZERO;

      unique case (cmd_type'(cmd))
         CMD_PUSH_FRONT: begin
            if (empty) begin
               we_c     = 1'b1;
               count_in = CW'(1);
            end else if (head_pos_ff == '0) begin
               status_c = ST_FULL;
            end else begin
               head_pos_in = head_pos_ff - AW'(1);
               if (head_off_ff == '0) begin
                  head_off_in = OW'(BLOCK_SIZE - 1);
                  head_blk_in = head_blk_ff - BW'(1);
               end else begin
                  head_off_in = head_off_ff - OW'(1);
               end
               we_c     = 1'b1;
               ram_addr = head_pos_ff - AW'(1);
               count_in = count_ff + CW'(1);
            end
         end
         CMD_PUSH_BACK: begin
            ram_addr = tail_pos_ff;
            if (empty) begin
               we_c     = 1'b1;
               count_in = CW'(1);
            end else if (tail_pos_ff == AW'(DEPTH - 1)) begin
               status_c = ST_FULL;
            end else begin
               tail_pos_in = tail_pos_ff + AW'(1);
               if (tail_off_ff == OW'(BLOCK_SIZE - 1)) begin
                  tail_off_in = '0;
                  tail_blk_in = tail_blk_ff + BW'(1);
               end else begin
                  tail_off_in = tail_off_ff + OW'(1);
               end
               we_c     = 1'b1;
               ram_addr = tail_pos_ff + AW'(1);
               count_in = count_ff + CW'(1);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (empty) begin
               status_c = ST_EMPTY;
               dsel_c   = DSEL_ONES;
            end else begin
               re_c     = 1'b1;
               dsel_c   = DSEL_RAM;
               ram_addr = (cmd_type'(cmd) == CMD_POP_FRONT) ? head_pos_ff : tail_pos_ff;
               count_in = count_ff - CW'(1);
               if (last) begin
                  // queue drains: park both ends mid-block of the last element
                  head_pos_in = mid_pos(head_blk_ff);
                  tail_pos_in = mid_pos(head_blk_ff);
                  head_off_in = OW'(MID_OFF);
                  tail_off_in = OW'(MID_OFF);
                  tail_blk_in = head_blk_ff;
               end else if (cmd_type'(cmd) == CMD_POP_FRONT) begin
                  head_pos_in = head_pos_ff + AW'(1);
                  if (head_off_ff == OW'(BLOCK_SIZE - 1)) begin
                     head_off_in = '0;
                     head_blk_in = head_blk_ff + BW'(1);
                  end else begin
                     head_off_in = head_off_ff + OW'(1);
                  end
               end else begin
                  tail_pos_in = tail_pos_ff - AW'(1);
                  if (tail_off_ff == '0) begin
                     tail_off_in = OW'(BLOCK_SIZE - 1);
                     tail_blk_in = tail_blk_ff - BW'(1);
                  end else begin
                     tail_off_in = tail_off_ff - OW'(1);
                  end
               end
            end
         end
         CMD_READ_IDX, CMD_WRITE_IDX: begin
            // in range means index < count, so the sum never passes the tail
            ram_addr = head_pos_ff + AW'(index);
            if (!in_range) begin
               status_c = ST_RANGE;
            end else if (cmd_type'(cmd) == CMD_READ_IDX) begin
               re_c   = 1'b1;
               dsel_c = DSEL_RAM;
            end else begin
               we_c = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_we      = accept && we_c;
   assign ram_re      = accept && re_c;
   assign resp.status = status_c;
   assign resp.dsel   = dsel_c;
   assign resp.count  = COUNT_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_pos_ff <= AW'(RESET_POS);
         tail_pos_ff <= AW'(RESET_POS);
         head_off_ff <= OW'(MID_OFF);
         tail_off_ff <= OW'(MID_OFF);
         head_blk_ff <= BW'(RESET_BLK);
         tail_blk_ff <= BW'(RESET_BLK);
         count_ff    <= '0;
      end else if (accept) begin
         head_pos_ff <= head_pos_in;
         tail_pos_ff <= tail_pos_in;
         head_off_ff <= head_off_in;
         tail_off_ff <= tail_off_in;
         head_blk_ff <= head_blk_in;
         tail_blk_ff <= tail_blk_in;
         count_ff    <= count_in;
      end
   end

endmodule

FILE: sv/segmented_deque.sv
// segmented double-ended queue over MAP_SLOTS blocks of BLOCK_SIZE entries
//
// req channel: one word per command (req_cmd, req_value, req_index), taken
//   at an edge where req_valid is high and req_stall is low; commands are
//   push front/back, pop front/back, read and write at an index from front
// rsp channel: exactly one word per command, in order, with rsp_data_out,
//   rsp_status and rsp_count (elements held after that command)
// response path: a taken command's word passes the synchronous element
//   ram read in the ram-read stage, then the output reg
// throughput: one command per cycle unless req_stall is high; pointers
//   update at the accepting edge; the single ram port does its read or write
// stall: while rsp_stall holds a waiting word, one more command is taken
//   into the ram-read stage, then req_stall rises until the output drains
// reset: synchronous, active high; both ends sit mid-block of the middle
//   block and the count is zero; element storage is not cleared, which is
//   safe since only written entries are ever read
module segmented_deque import sd_pkg::*; #(
   parameter int MAP_SLOTS  = MAP_SLOTS_DEF,
   parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [INDEX_W-1:0]        req_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_data_out,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]        rsp_count
);

   localparam int DEPTH = MAP_SLOTS * BLOCK_SIZE;
   localparam int AW    = $clog2(DEPTH);

   // handshake
   logic accept;
   logic advance;

   // control unit to ram and response path
   logic                         ram_we, ram_re;
   logic [AW-1:0]                ram_addr;
   logic signed [DATA_WIDTH-1:0] ram_wdata;
   logic [DATA_WIDTH-1:0]        ram_rdata;
   sd_resp_type                  resp_c;

   // ram-read stage
   logic        s1_valid_ff, s1_valid_in;
   sd_resp_type s1_resp_ff;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   // output register can load when empty or being drained
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // stored word is the low bits of the sign-extended value
   assign ram_wdata = DATA_WIDTH'(req_value);

   sd_ctrl #(
      .MAP_SLOTS  (MAP_SLOTS),
      .BLOCK_SIZE (BLOCK_SIZE)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .cmd      (req_cmd),
      .index    (req_index),
      .ram_we   (ram_we),
      .ram_re   (ram_re),
      .ram_addr (ram_addr),
      .resp     (resp_c)
   );

   // read data holds while no read is issued, so a stalled stage keeps it
   sd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign s1_valid_in  = (accept || advance) ? accept : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_comb begin
      case (s1_resp_ff.dsel)
         DSEL_RAM:  rsp_data_in = VALUE_W'($signed(ram_rdata));
         DSEL_ONES: rsp_data_in = '1;
         default:   rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_resp_ff <= resp_c;
      end
      if (s1_valid_ff && advance) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= s1_resp_ff.status;
         rsp_count_ff  <= s1_resp_ff.count;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

FILE: sv/sd_checker.sv
`include "segmented_deque_assert.svh"

module sd_checker import sd_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [CMD_W-1:0]          req_cmd,
   input logic signed [VALUE_W-1:0] req_value,
   input logic [INDEX_W-1:0]        req_index,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [VALUE_W-1:0] rsp_data_out,
   input logic [STATUS_W-1:0]       rsp_status,
   input logic [COUNT_W-1:0]        rsp_count
);

   logic empty_word;
   logic error_word;

   assign empty_word = rsp_valid && (rsp_status == ST_EMPTY);
   assign error_word = rsp_valid && ((rsp_status == ST_FULL) || (rsp_status == ST_RANGE));

   // empty pop carries all ones and leaves nothing behind
   `SD_ASSERT(a_empty_word, empty_word |-> (rsp_data_out == -1) && (rsp_count == '0), "empty pop")

   // full and range errors carry zero data
   `SD_ASSERT(a_error_zero, error_word |-> (rsp_data_out == '0), "error word carries data")

   // a stalled response word holds
   `SD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_status) && $stable(rsp_count), "stalled response changed")

   // no response word in the cycle after a reset edge
   `SD_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind segmented_deque sd_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_cmd      (req_cmd),
   .req_value    (req_value),
   .req_index    (req_index),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_data_out (rsp_data_out),
   .rsp_status   (rsp_status),
   .rsp_count    (rsp_count)
);
